### design/reorder_buffer_commit_retire_unit_defines.svh
// Assertion macros for the reorder buffer commit and retire unit.
`ifndef REORDER_BUFFER_COMMIT_RETIRE_UNIT_DEFINES_SVH
`define REORDER_BUFFER_COMMIT_RETIRE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle during reset.
`define RBCR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbcr assertion failed");

// Next-cycle implication, sampled on i_clk, idle during reset.
`define RBCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbcr assertion failed");

`endif

### design/rbcr_pkg.sv
// Shared types and constants of the reorder buffer commit and retire unit.
`timescale 1ns / 1ps
`default_nettype none

package rbcr_pkg;

    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int TAG_W     = 16;
    localparam int UOP_W     = 4;
    localparam int REQ_W     = 7;
    localparam int CNT_W     = 7;
    localparam int CTR_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RETIRE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIM      = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  op_tag;
        logic [UOP_W-1:0]  uop_number;
        logic [REQ_W-1:0]  request_count;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] alloc_slot;
        logic              can_allocate;
        logic [CNT_W-1:0]  flushed_count;
        logic [CNT_W-1:0]  freed_count;
        logic [CTR_W-1:0]  retired_ops_total;
        logic [CTR_W-1:0]  retired_insns_total;
        logic [CNT_W-1:0]  uncommitted_count;
        logic [CNT_W-1:0]  committed_count;
        logic              all_empty;
    } t_out;

    typedef struct packed {
        logic capture;
        logic exec;
        logic drain_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic drain_req;
        logic drain_more;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/rbcr_ctrl.sv
// Command sequencer of the reorder buffer commit and retire unit.
`timescale 1ns / 1ps
`default_nettype none

module rbcr_ctrl
    import rbcr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_ctrl,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                if (i_stat.drain_req) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.drain_more) begin
                    o_ctrl.drain_step = 1'b1;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

### design/rbcr_datapath.sv
// Ring pointers, region counts, retire marks, micro-op store and result registers.
`timescale 1ns / 1ps
`default_nettype none

module rbcr_datapath
    import rbcr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire t_in                   i_cmd,
    input  wire t_ctrl_cmd             i_ctrl,
    output t_dp_stat                   o_stat,
    output t_out                       o_result
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int AW = ((CW > REQ_W) ? CW : REQ_W) + 1;
    localparam int XW = ((CW > PW + 1) ? CW : PW + 1);
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] prev_ptr(input logic [PW-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    t_in                   r_cmd;
    logic [UOP_W-1:0]      r_uop;
    logic [UOP_W-1:0]      r_uop_mem [RING_DEPTH];

    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_commit, n_commit;
    logic [PW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_com, n_com;
    logic [CW-1:0]         r_unc, n_unc;
    logic [CTR_W-1:0]      r_ops, n_ops;
    logic [CTR_W-1:0]      r_insns, n_insns;
    logic [RING_DEPTH-1:0] r_marks, n_marks;

    logic [REQ_W-1:0]      r_cap;
    logic                  r_roc;
    logic                  r_sim;

    logic [1:0]            r_status, n_status;
    logic [PW-1:0]         r_alloc, n_alloc;
    logic                  r_can, n_can;
    logic [CW-1:0]         r_flushed, n_flushed;
    logic [CW-1:0]         r_freed, n_freed;

    logic [PW-1:0]         slot_idx;
    logic                  in_ring;
    logic [CW:0]           occ;
    logic                  is_full;
    logic [PW:0]           diff;
    logic [PW:0]           off;
    logic                  flush_hit;
    logic [AW-1:0]         cur;
    logic                  fits;
    logic                  commit_miss;
    logic                  head_op;
    logic                  mem_we;

    assign slot_idx    = PW'(r_cmd.slot);
    assign in_ring     = 32'(r_cmd.slot) < 32'(RING_DEPTH);
    assign occ         = {1'b0, r_com} + {1'b0, r_unc};
    assign is_full     = occ >= (CW + 1)'(RING_DEPTH);
    assign diff        = {1'b0, slot_idx} - {1'b0, r_commit};
    assign off         = diff[PW] ? diff + (PW + 1)'(RING_DEPTH) : diff;
    assign flush_hit   = in_ring && (XW'(off) < XW'(r_unc));
    assign cur         = r_roc ? AW'(r_unc) : AW'(r_unc) + AW'(r_com);
    assign fits        = (AW'(r_cmd.request_count) + cur) <= AW'(r_cap);
    assign commit_miss = 32'(r_commit) != 32'(r_cmd.slot);
    assign head_op     = in_ring ? (r_uop == '0) : 1'b1;

    always_comb begin
        n_head    = r_head;
        n_commit  = r_commit;
        n_tail    = r_tail;
        n_com     = r_com;
        n_unc     = r_unc;
        n_ops     = r_ops;
        n_insns   = r_insns;
        n_marks   = r_marks;
        n_status  = r_status;
        n_alloc   = r_alloc;
        n_can     = r_can;
        n_flushed = r_flushed;
        n_freed   = r_freed;
        mem_we    = 1'b0;
        if (i_ctrl.exec) begin
            n_status  = ST_OK;
            n_alloc   = '0;
            n_can     = 1'b0;
            n_flushed = '0;
            n_freed   = '0;
            case (r_cmd.mode)
                MODE_ALLOC: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we          = 1'b1;
                        n_marks[r_tail] = 1'b0;
                        n_alloc         = r_tail;
                        n_tail          = next_ptr(r_tail);
                        n_unc           = r_unc + 1'b1;
                    end
                end
                MODE_POP: begin
                    if (r_unc == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_tail = prev_ptr(r_tail);
                        n_unc  = r_unc - 1'b1;
                    end
                end
                MODE_COMMIT: begin
                    if (r_sim) begin
                        if (r_unc == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            if (commit_miss) begin
                                n_status = ST_MISMATCH;
                            end
                            n_marks[r_commit] = 1'b0;
                            n_commit          = next_ptr(r_commit);
                            n_unc             = r_unc - 1'b1;
                            n_com             = r_com + 1'b1;
                        end
                    end
                end
                MODE_RETIRE: begin
                    if (r_sim && in_ring) begin
                        n_marks[slot_idx] = 1'b1;
                    end
                    if (head_op) begin
                        n_insns = r_insns + 1'b1;
                    end
                    n_ops = r_ops + 1'b1;
                end
                MODE_FLUSH: begin
                    if (flush_hit) begin
                        n_flushed = r_unc - CW'(off);
                        n_unc     = CW'(off);
                        n_tail    = slot_idx;
                    end
                end
                MODE_QUERY: begin
                    n_can = fits;
                end
                default: begin
                end
            endcase
        end else if (i_ctrl.drain_step) begin
            n_marks[r_head] = 1'b0;
            n_head          = next_ptr(r_head);
            n_com           = r_com - 1'b1;
            n_freed         = r_freed + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_commit <= '0;
            r_tail   <= '0;
            r_com    <= '0;
            r_unc    <= '0;
            r_ops    <= '0;
            r_insns  <= '0;
            r_marks  <= '0;
            r_cap    <= REQ_W'(64);
            r_roc    <= 1'b0;
            r_sim    <= 1'b1;
        end else begin
            r_head   <= n_head;
            r_commit <= n_commit;
            r_tail   <= n_tail;
            r_com    <= n_com;
            r_unc    <= n_unc;
            r_ops    <= n_ops;
            r_insns  <= n_insns;
            r_marks  <= n_marks;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap <= i_cfg_data;
                    CFG_REMOVE:   r_roc <= i_cfg_data[0];
                    CFG_SIM:      r_sim <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_alloc   <= n_alloc;
        r_can     <= n_can;
        r_flushed <= n_flushed;
        r_freed   <= n_freed;
        if (i_ctrl.capture) begin
            r_cmd <= i_cmd;
            r_uop <= r_uop_mem[PW'(i_cmd.slot)];
        end
        if (mem_we) begin
            r_uop_mem[r_tail] <= r_cmd.uop_number;
        end
    end

    assign o_stat.drain_req  = (r_cmd.mode == MODE_RETIRE) && r_sim;
    assign o_stat.drain_more = (r_com != '0) && r_marks[r_head];

    assign o_result.status              = r_status;
    assign o_result.alloc_slot          = SLOT_W'(r_alloc);
    assign o_result.can_allocate        = r_can;
    assign o_result.flushed_count       = CNT_W'(r_flushed);
    assign o_result.freed_count         = CNT_W'(r_freed);
    assign o_result.retired_ops_total   = r_ops;
    assign o_result.retired_insns_total = r_insns;
    assign o_result.uncommitted_count   = CNT_W'(r_unc);
    assign o_result.committed_count     = CNT_W'(r_com);
    assign o_result.all_empty           = (r_unc == '0) && (r_com == '0);

endmodule

`default_nettype wire

### design/reorder_buffer_commit_retire_unit.sv
// Top level of the reorder buffer commit and retire unit.
// A command is taken when start is high and busy is low. Every command
// produces one result, shown on o_result for the single cycle in which
// o_done is high; the receiver cannot stall it, so capture it then. A new
// command may be started in the strobe cycle. The execute state's result
// is registered with the done strobe, except for a retire with simulation
// mode set, which drains the head before its strobe: the drain frees one
// head entry per cycle while it is committed and marked retired.
// Retire marks sit in flip-flops cleared by reset, so no clearing pass follows
// reset. Write the configuration registers only while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "reorder_buffer_commit_retire_unit_defines.svh"

module reorder_buffer_commit_retire_unit
    import rbcr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in                   i_cmd,
    output logic                       o_done,
    output t_out                       o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data
);

    t_ctrl_cmd ctrl;
    t_dp_stat  stat;

    rbcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    rbcr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_result    (o_result)
    );

    `RBCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_done)
    `RBCR_ASSERT_NOW(a_done_after_work, o_done, !busy && $past(busy))
    `RBCR_ASSERT_NOW(a_drain_only_busy, ctrl.drain_step, busy && !ctrl.exec && !ctrl.capture)

endmodule

`default_nettype wire

### test/rob_commit_checker.sv
// Checker that predicts each result of the reorder buffer unit and compares it with the DUT.
`timescale 1ns / 1ps

module rob_commit_checker
    import rbcr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire t_in                  i_cmd,
    input  wire logic                 i_done,
    input  wire t_out                 i_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                        o_pending,
    output int                        o_errors,
    output logic [SLOT_W-1:0]         o_head,
    output logic [SLOT_W-1:0]         o_commit,
    output logic [SLOT_W-1:0]         o_tail,
    output logic [CNT_W-1:0]          o_committed,
    output logic [CNT_W-1:0]          o_uncommitted,
    output logic [63:0]               o_written
);

    localparam int RING_SLOTS   = 64;
    localparam int REPORT_MAX   = 10;
    localparam int EXPECT_SLOTS = 4;

    logic [UOP_W-1:0]      uop_mem [RING_SLOTS];
    logic [RING_SLOTS-1:0] retire_mark;
    logic [RING_SLOTS-1:0] slot_written;
    logic [SLOT_W-1:0]     head_slot;
    logic [SLOT_W-1:0]     commit_slot;
    logic [SLOT_W-1:0]     tail_slot;
    int                    n_committed;
    int                    n_uncommitted;
    logic [CTR_W-1:0]      ops_total;
    logic [CTR_W-1:0]      insns_total;
    logic [CFG_DAT_W-1:0]  capacity;
    logic                  exclude_committed;
    logic                  list_update;
    t_out                  expected_mem [EXPECT_SLOTS];
    int                    expect_wr = 0;
    int                    expect_rd = 0;
    int                    error_total = 0;
    int                    results_seen = 0;

    function automatic void rob_clear();
        retire_mark       = '0;
        slot_written      = '0;
        head_slot         = '0;
        commit_slot       = '0;
        tail_slot         = '0;
        n_committed       = 0;
        n_uncommitted     = 0;
        ops_total         = '0;
        insns_total       = '0;
        capacity          = CFG_DAT_W'(64);
        exclude_committed = 1'b0;
        list_update       = 1'b1;
    endfunction

    function automatic t_out rob_step(input t_in c);
        t_out             r;
        logic [SLOT_W-1:0] offset;
        int               freed;
        int               occupancy;
        r     = '0;
        freed = 0;
        case (c.mode)
            MODE_ALLOC: begin
                if (n_committed + n_uncommitted >= RING_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    uop_mem[tail_slot]      = c.uop_number;
                    retire_mark[tail_slot]  = 1'b0;
                    slot_written[tail_slot] = 1'b1;
                    r.alloc_slot            = tail_slot;
                    tail_slot               = tail_slot + 1'b1;
                    n_uncommitted++;
                end
            end
            MODE_POP: begin
                if (n_uncommitted == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    tail_slot = tail_slot - 1'b1;
                    n_uncommitted--;
                end
            end
            MODE_COMMIT: begin
                if (list_update) begin
                    if (n_uncommitted == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        if (commit_slot != c.slot) r.status = ST_MISMATCH;
                        retire_mark[commit_slot] = 1'b0;
                        commit_slot = commit_slot + 1'b1;
                        n_uncommitted--;
                        n_committed++;
                    end
                end
            end
            MODE_RETIRE: begin
                if (uop_mem[c.slot] == '0) insns_total = insns_total + 1'b1;
                ops_total = ops_total + 1'b1;
                if (list_update) begin
                    retire_mark[c.slot] = 1'b1;
                    while (n_committed > 0 && retire_mark[head_slot]) begin
                        retire_mark[head_slot] = 1'b0;
                        head_slot = head_slot + 1'b1;
                        n_committed--;
                        freed++;
                    end
                end
            end
            MODE_FLUSH: begin
                offset = c.slot - commit_slot;
                if (int'(offset) < n_uncommitted) begin
                    r.flushed_count = CNT_W'(n_uncommitted - int'(offset));
                    n_uncommitted   = int'(offset);
                    tail_slot       = c.slot;
                end
            end
            MODE_QUERY: begin
                occupancy = n_uncommitted + (exclude_committed ? 0 : n_committed);
                r.can_allocate = (int'(c.request_count) + occupancy <= int'(capacity));
            end
            default: begin
            end
        endcase
        r.freed_count         = CNT_W'(freed);
        r.retired_ops_total   = ops_total;
        r.retired_insns_total = insns_total;
        r.uncommitted_count   = CNT_W'(n_uncommitted);
        r.committed_count     = CNT_W'(n_committed);
        r.all_empty           = (n_uncommitted == 0 && n_committed == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_total++;
            if (error_total <= REPORT_MAX)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            rob_clear();
            expect_wr = 0;
            expect_rd = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: capacity          = i_cfg_data;
                    CFG_REMOVE:   exclude_committed = i_cfg_data[0];
                    CFG_SIM:      list_update       = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_done) begin
                results_seen++;
                if (expect_wr == expect_rd) begin
                    error_total++;
                    if (error_total <= REPORT_MAX)
                        $display("result %0d: no command outstanding", results_seen);
                end else begin
                    want = expected_mem[expect_rd % EXPECT_SLOTS];
                    expect_rd++;
                    check_field("status", want.status, i_result.status);
                    check_field("alloc_slot", want.alloc_slot, i_result.alloc_slot);
                    check_field("can_allocate", want.can_allocate, i_result.can_allocate);
                    check_field("flushed_count", want.flushed_count, i_result.flushed_count);
                    check_field("freed_count", want.freed_count, i_result.freed_count);
                    check_field("retired_ops_total", want.retired_ops_total,
                                i_result.retired_ops_total);
                    check_field("retired_insns_total", want.retired_insns_total,
                                i_result.retired_insns_total);
                    check_field("uncommitted_count", want.uncommitted_count,
                                i_result.uncommitted_count);
                    check_field("committed_count", want.committed_count,
                                i_result.committed_count);
                    check_field("all_empty", want.all_empty, i_result.all_empty);
                end
            end
            if (i_start && !i_busy) begin
                if (expect_wr - expect_rd >= EXPECT_SLOTS) begin
                    error_total++;
                    if (error_total <= REPORT_MAX)
                        $display("too many commands outstanding");
                end else begin
                    expected_mem[expect_wr % EXPECT_SLOTS] = rob_step(i_cmd);
                    expect_wr++;
                end
            end
        end
        o_pending     <= expect_wr - expect_rd;
        o_errors      <= error_total;
        o_head        <= head_slot;
        o_commit      <= commit_slot;
        o_tail        <= tail_slot;
        o_committed   <= CNT_W'(n_committed);
        o_uncommitted <= CNT_W'(n_uncommitted);
        o_written     <= slot_written;
    end

endmodule

### test/testbench.sv
// Testbench top for the reorder buffer unit: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import rbcr_pkg::*;

    localparam int unsigned       WATCHDOG_LIMIT = 1000;
    localparam int                SEGMENTS       = 6;
    localparam int                DRAIN_CYCLES   = 80;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    typedef enum int {
        BIAS_MIX,
        BIAS_FILL,
        BIAS_DRAIN
    } t_bias;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in                  i_cmd;
    logic                 o_done;
    t_out                 o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    int                   pending_results;
    int                   error_count;
    logic [SLOT_W-1:0]    rob_head;
    logic [SLOT_W-1:0]    rob_commit;
    logic [SLOT_W-1:0]    rob_tail;
    logic [CNT_W-1:0]     rob_committed;
    logic [CNT_W-1:0]     rob_uncommitted;
    logic [63:0]          rob_written;

    int unsigned          sender_idle;
    t_bias                stim_bias;
    int                   mode_hits [8];
    int unsigned          quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    reorder_buffer_commit_retire_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rob_commit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_done        (o_done),
        .i_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending_results),
        .o_errors      (error_count),
        .o_head        (rob_head),
        .o_commit      (rob_commit),
        .o_tail        (rob_tail),
        .o_committed   (rob_committed),
        .o_uncommitted (rob_uncommitted),
        .o_written     (rob_written)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_in next_command();
        t_in         c;
        int unsigned pick;
        int unsigned span;
        int unsigned w_alloc, w_commit, w_retire, w_pop, w_flush, w_query;
        c.mode          = MODE_QUERY;
        c.slot          = SLOT_W'($urandom_range(63));
        c.op_tag        = TAG_W'($urandom_range(65535));
        c.uop_number    = ($urandom_range(99) < 40) ? '0 : UOP_W'($urandom_range(15));
        c.request_count = ($urandom_range(99) < 70) ? REQ_W'($urandom_range(64))
                                                    : REQ_W'($urandom_range(127));
        case (stim_bias)
            BIAS_FILL: begin
                w_alloc = 70; w_commit = 10; w_retire = 10; w_pop = 3; w_flush = 2; w_query = 3;
            end
            BIAS_DRAIN: begin
                w_alloc = 12; w_commit = 33; w_retire = 40; w_pop = 4; w_flush = 4; w_query = 4;
            end
            default: begin
                w_alloc = 30; w_commit = 22; w_retire = 22; w_pop = 6; w_flush = 8; w_query = 9;
            end
        endcase
        pick = $urandom_range(99);
        if (pick < w_alloc) c.mode = MODE_ALLOC;
        else if (pick < w_alloc + w_commit) c.mode = MODE_COMMIT;
        else if (pick < w_alloc + w_commit + w_retire) c.mode = MODE_RETIRE;
        else if (pick < w_alloc + w_commit + w_retire + w_pop) c.mode = MODE_POP;
        else if (pick < w_alloc + w_commit + w_retire + w_pop + w_flush) c.mode = MODE_FLUSH;
        else if (pick < w_alloc + w_commit + w_retire + w_pop + w_flush + w_query)
            c.mode = MODE_QUERY;
        else c.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;

        if (c.mode == MODE_COMMIT && $urandom_range(9) != 0) c.slot = rob_commit;
        if (c.mode == MODE_FLUSH && rob_uncommitted != 0 && $urandom_range(4) != 0) begin
            span = (rob_uncommitted > 4 && $urandom_range(1) == 1) ? 4 : rob_uncommitted;
            c.slot = rob_tail - SLOT_W'($urandom_range(span, 1));
        end
        if (c.mode == MODE_RETIRE) begin
            if (rob_written == '0) begin
                c.mode = MODE_ALLOC;
            end else begin
                if (rob_committed != 0 && $urandom_range(99) < 85)
                    c.slot = rob_head + SLOT_W'($urandom_range(rob_committed - 1));
                // step to a slot whose micro-op number has been stored
                while (!rob_written[c.slot]) c.slot = c.slot + 1'b1;
            end
        end
        return c;
    endfunction

    task automatic pause();
        @(posedge i_clk);
        while ($urandom_range(99) < sender_idle) @(posedge i_clk);
    endtask

    task automatic launch(input t_in c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (!(start && !busy));
        start <= 1'b0;
        mode_hits[c.mode]++;
    endtask

    task automatic issue(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                         input logic [TAG_W-1:0] tag, input logic [UOP_W-1:0] uop,
                         input logic [REQ_W-1:0] req);
        t_in c;
        c = '{mode: mode, slot: slot, op_tag: tag, uop_number: uop, request_count: req};
        pause();
        launch(c);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DAT_W-1:0] cap;
        logic                 rem;
        logic                 sim;
        int                   count;
        int                   total;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sender_idle = 35;
        stim_bias   = BIAS_MIX;
        mode_hits   = '{default: 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin cap = CFG_DAT_W'(64); rem = 1'b0; sim = 1'b1; end
                1: begin cap = CFG_DAT_W'(1);  rem = 1'b1; sim = 1'b1; end
                2: begin cap = CFG_DAT_W'(64); rem = 1'b1; sim = 1'b0; end
                3: begin cap = CFG_DAT_W'($urandom_range(63, 2)); rem = 1'b0; sim = 1'b1; end
                4: begin cap = CFG_DAT_W'(32); rem = 1'b1; sim = 1'b1; end
                default: begin
                    cap = CFG_DAT_W'($urandom_range(64, 1));
                    rem = 1'($urandom_range(1));
                    sim = 1'b1;
                end
            endcase
            sender_idle = (seg < 2) ? 35 : (seg < 4) ? 61 : 0;
            wait_drained();
            write_register(CFG_CAPACITY, cap);
            write_register(CFG_REMOVE, CFG_DAT_W'(rem));
            write_register(CFG_SIM, CFG_DAT_W'(sim));
            i_cfg_we <= 1'b0;

            if (seg == 0) begin
                issue(MODE_POP,      6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_COMMIT,   6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_FLUSH,    6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_QUERY,    6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_QUERY,    6'd0,  16'h0000, 4'd0,  7'd64);
                issue(MODE_QUERY,    6'd0,  16'h0000, 4'd0,  7'd65);
                issue(MODE_QUERY,    6'd63, 16'hFFFF, 4'd15, 7'd127);
                issue(MODE_SPARE_LO, 6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_SPARE_HI, 6'd63, 16'hFFFF, 4'd15, 7'd127);
                issue(MODE_ALLOC,    6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_ALLOC,    6'd63, 16'hFFFF, 4'd15, 7'd0);
                issue(MODE_ALLOC,    6'd0,  16'h1234, 4'd0,  7'd0);
                issue(MODE_ALLOC,    6'd0,  16'h00FF, 4'd1,  7'd0);
                issue(MODE_COMMIT,   6'd63, 16'h0000, 4'd0,  7'd0);
                issue(MODE_COMMIT,   6'd1,  16'h0000, 4'd0,  7'd0);
                issue(MODE_QUERY,    6'd0,  16'h0000, 4'd0,  7'd62);
                issue(MODE_RETIRE,   6'd1,  16'h0000, 4'd0,  7'd0);
                issue(MODE_RETIRE,   6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_FLUSH,    6'd3,  16'h0000, 4'd0,  7'd0);
                issue(MODE_FLUSH,    6'd40, 16'h0000, 4'd0,  7'd0);
                issue(MODE_POP,      6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_POP,      6'd0,  16'h0000, 4'd0,  7'd0);
                issue(MODE_RETIRE,   6'd3,  16'h0000, 4'd0,  7'd0);
                issue(MODE_ALLOC,    6'd0,  16'hA5A5, 4'd7,  7'd0);
            end

            count = (seg == 2) ? 200 : 330;
            for (int n = 0; n < count; n++) begin
                if (n % 40 == 0) stim_bias = t_bias'($urandom_range(2));
                pause();
                launch(next_command());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        total = 0;
        foreach (mode_hits[m]) total += mode_hits[m];
        $display("Ran %0d commands in %0d register settings: %0d allocate, %0d pop, %0d commit,",
                 total, SEGMENTS, mode_hits[MODE_ALLOC], mode_hits[MODE_POP],
                 mode_hits[MODE_COMMIT]);
        $display("  %0d retire, %0d flush, %0d query, %0d unused mode; capacity 1 to 64, lists %s",
                 mode_hits[MODE_RETIRE], mode_hits[MODE_FLUSH], mode_hits[MODE_QUERY],
                 mode_hits[MODE_SPARE_LO] + mode_hits[MODE_SPARE_HI], "updated and frozen");
        if (pending_results != 0) $display("%0d results never arrived", pending_results);
        if (error_count == 0 && pending_results == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
